FILE: rtl/oaht_pkg.sv
package oaht_pkg;

  // number of slots, a power of two
  localparam int SLOTS = 256;

  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_SET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;

  localparam logic [1:0] TAG_BOOL   = 2'd0;
  localparam logic [1:0] TAG_NIL    = 2'd1;
  localparam logic [1:0] TAG_NUMBER = 2'd2;
  localparam logic [1:0] TAG_OBJECT = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NILKEY   = 2'd3;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  opcode;
    logic        skip;       // answered without probing
    logic [1:0]  skip_status;
    logic [1:0]  key_type;
    logic [63:0] key_bits;
    logic [31:0] hash;
    logic [1:0]  value_type;
    logic [63:0] value_bits;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        new_key;
    logic [1:0]  found_type;
    logic [63:0] found_bits;
  } rsp_t;

  // first half of the 64-to-32 mix, up to the multiply by 21
  function automatic logic [63:0] mix_a(input logic [63:0] k);
    logic [63:0] h;
    h = ~k + (k << 18);
    h = h ^ (h >> 31);
    return h;
  endfunction

  // 21*h = h + (h<<2) + (h<<4), then the remaining steps
  function automatic logic [31:0] mix_b(input logic [63:0] a);
    logic [63:0] h;
    h = a + (a << 2) + (a << 4);
    h = h ^ (h >> 11);
    h = h + (h << 6);
    h = h ^ (h >> 22);
    return h[31:0];
  endfunction

endpackage

FILE: rtl/open_addressing_hash_table_unit.sv
// open addressing hash table: get/set/delete on typed 64-bit keys with linear
// probing and tombstone reuse over oaht_pkg::SLOTS slots (a power of two).
// after reset the probe engine sweeps every slot of the table to empty; the
// front end and queue still take up to four transactions meanwhile. a
// transaction passes the hash front end and the queue; the probe engine
// picks it up, reads one slot at a time (slot memory with registered read,
// a read state then a check state per slot) and settles the outcome in a
// write state before the result is offered. a nil key or unknown opcode
// skips the probe and is offered straight after the probe engine picks it up.
// the probe engine takes the next request only after the result is taken. a
// set that would fill a fresh slot past three quarters of SLOTS answers table
// full.
module open_addressing_hash_table_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[1:0], key_type[3:2], key_bits[67:4], key_is_string[68],
  // key_string_hash[100:69], value_type[102:101], value_bits[166:103]
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], new_key[2], found_type[4:3], found_bits[68:5]
  output logic [71:0]  out_tdata
);
  import oaht_pkg::*;

  logic f_valid, f_ready, b_valid, b_ready;
  req_t f_data, b_data;
  rsp_t rsp;

  oaht_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .opcode(in_tdata[1:0]), .key_type(in_tdata[3:2]), .key_bits(in_tdata[67:4]),
    .key_is_string(in_tdata[68]), .key_string_hash(in_tdata[100:69]),
    .value_type(in_tdata[102:101]), .value_bits(in_tdata[166:103]),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  oaht_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  oaht_back u_back (
    .clk, .rst_n,
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(rsp)
  );

  assign out_tdata = {3'd0, rsp.found_bits, rsp.found_type, rsp.new_key, rsp.status};
endmodule

FILE: rtl/oaht_front.sv
module oaht_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          opcode,
  input  logic [1:0]          key_type,
  input  logic [63:0]         key_bits,
  input  logic                key_is_string,
  input  logic [31:0]         key_string_hash,
  input  logic [1:0]          value_type,
  input  logic [63:0]         value_bits,
  output logic                q_valid,
  input  logic                q_ready,
  output oaht_pkg::req_t      q_data
);
  import oaht_pkg::*;

  // stage 1: first mix half; stage 2: finish hash
  logic        s1_valid_r;
  req_t        s1_r;
  logic [63:0] s1_mix_r;
  logic        s1_str_r;
  logic        s2_valid_r;
  req_t        s2_r;
  logic        s2_ready, s1_ready;
  logic [63:0] kb;
  req_t        s1_nxt, s2_nxt;

  assign s2_ready = !s2_valid_r || q_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;
  assign q_valid  = s2_valid_r;
  assign q_data   = s2_r;

  always_comb begin
    kb = (key_type == TAG_BOOL) ? {63'd0, key_bits[0]} : key_bits;
    s1_nxt = '0;
    s1_nxt.opcode     = opcode;
    s1_nxt.key_type   = key_type;
    s1_nxt.key_bits   = kb;
    s1_nxt.value_type = value_type;
    s1_nxt.value_bits = value_bits;
    if (opcode != OP_GET && opcode != OP_SET && opcode != OP_DEL) begin
      s1_nxt.skip = 1'b1;
      s1_nxt.skip_status = ST_NOTFOUND;
    end else if (key_type == TAG_NIL) begin
      s1_nxt.skip = 1'b1;
      s1_nxt.skip_status = ST_NILKEY;
    end
    if (key_type == TAG_BOOL) s1_nxt.hash = kb[0] ? 32'd3 : 32'd1;
    else if (key_type == TAG_NIL) s1_nxt.hash = 32'd2;
    else s1_nxt.hash = key_string_hash;
  end

  always_comb begin
    s2_nxt = s1_r;
    if (s1_r.key_type == TAG_NUMBER || (s1_r.key_type == TAG_OBJECT && !s1_str_r))
      s2_nxt.hash = mix_b(s1_mix_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
    if (s1_ready && in_valid) begin
      s1_r     <= s1_nxt;
      s1_mix_r <= mix_a(kb);
      s1_str_r <= key_is_string;
    end
    if (s2_ready && s1_valid_r) s2_r <= s2_nxt;
  end
endmodule

FILE: rtl/oaht_queue.sv
module oaht_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  oaht_pkg::req_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output oaht_pkg::req_t rd_data
);
  import oaht_pkg::*;

  // two-entry fifo
  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

FILE: rtl/oaht_back.sv
module oaht_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  oaht_pkg::req_t q_data,
  output logic           out_valid,
  input  logic           out_ready,
  output oaht_pkg::rsp_t out_data
);
  import oaht_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = AW + 1;
  localparam logic [CW+1:0] LIMIT = (CW+2)'(3 * SLOTS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // slot word: key type, key bits, value type, value bits
  localparam int DW = 132;
  logic [DW-1:0] mem [SLOTS];
  logic [DW-1:0] rd_r;
  logic [DW-1:0] wr_word;
  logic          we;
  logic [AW-1:0] waddr;

  logic [2:0]    state_r;
  req_t          req_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] tomb_r;
  logic          have_tomb_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] used_r;
  logic [AW-1:0] tgt_r;
  logic          hit_r;
  logic          tgt_ok_r;
  rsp_t          rsp_r;

  logic [1:0]  s_kt, s_vt;
  logic [63:0] s_kb;

  // set writes a fresh slot only if load allows; tombstone reuse is free
  logic          fresh;
  logic          keep;
  logic [CW+1:0] need;
  rsp_t          fin_rsp;
  rsp_t          skip_rsp;

  assign s_kt = rd_r[131:130];
  assign s_kb = rd_r[129:66];
  assign s_vt = rd_r[65:64];

  assign q_ready   = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_data  = rsp_r;

  assign fresh = !hit_r && !(have_tomb_r && tgt_r == tomb_r);
  assign need  = ({2'b0, used_r} + 1'b1) << 2;

  always_comb begin
    keep = 1'b0;
    case (req_r.opcode)
      OP_DEL:  keep = hit_r;
      OP_SET:  keep = tgt_ok_r && !(fresh && need > LIMIT);
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    skip_rsp = '0;
    skip_rsp.status = q_data.skip_status;
  end

  // outcome of a probed request, rd_r still holds the slot that was hit
  always_comb begin
    fin_rsp = '0;
    case (req_r.opcode)
      OP_GET: begin
        fin_rsp.status = hit_r ? ST_OK : ST_NOTFOUND;
        if (hit_r) begin
          fin_rsp.found_type = s_vt;
          fin_rsp.found_bits = rd_r[63:0];
        end
      end
      OP_DEL: fin_rsp.status = hit_r ? ST_OK : ST_NOTFOUND;
      default: begin
        if (!keep) begin
          fin_rsp.status = ST_FULL;
        end else begin
          fin_rsp.status = ST_OK;
          fin_rsp.new_key = !hit_r;
        end
      end
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = tgt_r;
    wr_word = {req_r.key_type, req_r.key_bits, req_r.value_type, req_r.value_bits};
    if (state_r == S_CLEAR) begin
      we = 1'b1;
      waddr = idx_r;
      wr_word = {TAG_NIL, 64'd0, TAG_NIL, 64'd0};
    end else if (state_r == S_WRITE) begin
      we = keep;
      if (req_r.opcode == OP_DEL) wr_word = {TAG_NIL, 64'd0, TAG_BOOL, 64'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wr_word;
    rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
      used_r  <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == AW'(SLOTS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            req_r <= q_data;
            idx_r <= q_data.hash[AW-1:0];
            have_tomb_r <= 1'b0;
            n_r <= '0;
            rsp_r <= skip_rsp;
            if (q_data.skip) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: state_r <= S_CHECK;
        S_CHECK: begin
          if (s_kt == TAG_NIL && s_vt == TAG_NIL) begin
            hit_r <= 1'b0;
            tgt_ok_r <= 1'b1;
            tgt_r <= have_tomb_r ? tomb_r : idx_r;
            state_r <= S_WRITE;
          end else if (s_kt != TAG_NIL && s_kt == req_r.key_type && s_kb == req_r.key_bits) begin
            hit_r <= 1'b1;
            tgt_ok_r <= 1'b1;
            tgt_r <= idx_r;
            state_r <= S_WRITE;
          end else begin
            if (s_kt == TAG_NIL && !have_tomb_r) begin
              have_tomb_r <= 1'b1;
              tomb_r <= idx_r;
            end
            if (n_r == CW'(SLOTS - 1)) begin
              hit_r <= 1'b0;
              tgt_ok_r <= have_tomb_r || s_kt == TAG_NIL;
              tgt_r <= have_tomb_r ? tomb_r : idx_r;
              state_r <= S_WRITE;
            end else begin
              n_r <= n_r + 1'b1;
              idx_r <= idx_r + 1'b1;
              state_r <= S_READ;
            end
          end
        end
        S_WRITE: begin
          // decide outcome; memory write happens this cycle only when kept
          rsp_r <= fin_rsp;
          if (req_r.opcode == OP_SET && keep && fresh) used_r <= used_r + 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
